@@ rtl/hufd_pkg.sv @@
package hufd_pkg;

	// Node table geometry and field widths
	localparam int NODE_COUNT = 512;
	localparam int IDX_W = 9;
	localparam int SYM_W = 8;
	localparam int CODE_W = 8;
	localparam int CNT_W = $clog2(CODE_W + 1);

	// Configuration register map
	localparam int ROOT_W = IDX_W;
	localparam logic REG_ROOT = 1'b0;

	// Item actions
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [SYM_W-1:0] sym;
	} node_t;

	typedef struct packed {
		logic action;
		logic [IDX_W-1:0] node_index;
		logic [IDX_W-1:0] left_child;
		logic [IDX_W-1:0] right_child;
		logic [SYM_W-1:0] node_symbol;
		logic [CODE_W-1:0] code_byte;
	} in_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic last;
	} out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic write_node;
		logic load;
		logic go_root;
		logic step;
		logic eval;
		logic issue;
		logic hold_load;
		logic push;
		logic push_last;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic leaf;
	} sts_t;

endpackage

@@ rtl/hufd_dp.sv @@
module hufd_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hufd_pkg::cmd_t               cmd,
	input  hufd_pkg::in_t                in_data,
	input  logic [hufd_pkg::ROOT_W-1:0]  root_index,
	output hufd_pkg::sts_t               sts,
	output hufd_pkg::out_t               out_data
);

	hufd_pkg::node_t mem [hufd_pkg::NODE_COUNT];
	hufd_pkg::node_t rd_a_q;
	hufd_pkg::node_t root_rd_q;
	hufd_pkg::node_t cur;
	hufd_pkg::node_t wr_node;
	hufd_pkg::out_t out_q;
	logic [hufd_pkg::CODE_W-1:0] shift_q;
	logic [hufd_pkg::SYM_W-1:0] hold_sym_q;
	logic [hufd_pkg::IDX_W-1:0] addr;
	logic at_root_q;
	logic leaf;
	logic cur_from_root;

	// Pick the node the walk stands on, then the child for the next bit
	always_comb begin
		leaf = (rd_a_q.sym != '0);
		cur_from_root = cmd.eval ? leaf : at_root_q;
		cur = cur_from_root ? root_rd_q : rd_a_q;
		addr = shift_q[hufd_pkg::CODE_W-1] ? cur.left : cur.right;
		wr_node = '{left: in_data.left_child, right: in_data.right_child,
			sym: in_data.node_symbol};
	end

	assign sts.leaf = leaf;
	assign out_data = out_q;

	// Node table: one write port, child read port and root read port
	always_ff @(posedge clk) begin
		if (cmd.write_node) begin
			mem[in_data.node_index] <= wr_node;
		end
		if (cmd.issue) begin
			rd_a_q <= mem[addr];
		end
		root_rd_q <= mem[root_index];
	end

	// Track whether the walk sits at the root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_root_q <= 1'b1;
		end else if (cmd.go_root) begin
			at_root_q <= 1'b1;
		end else if (cmd.step) begin
			at_root_q <= cur_from_root;
		end
	end

	// Code bits, held symbol and output payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shift_q <= in_data.code_byte;
		end else if (cmd.issue) begin
			shift_q <= {shift_q[hufd_pkg::CODE_W-2:0], 1'b0};
		end
		if (cmd.hold_load) begin
			hold_sym_q <= rd_a_q.sym;
		end
		if (cmd.push) begin
			out_q <= '{symbol: hold_sym_q, last: cmd.push_last};
		end
	end

endmodule

@@ rtl/hufd_ctrl.sv @@
module hufd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_action,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  logic            cfg_wr,
	input  hufd_pkg::sts_t  sts,
	output hufd_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic [hufd_pkg::CNT_W-1:0] cnt_q;
	logic hold_v_q;
	logic out_valid_q;
	logic push_ok;
	logic pend;
	logic leaf_e;
	logic step;
	logic last_bit;
	logic flush_ok;
	logic accept;
	logic acc_decode;

	// Work out stalls and issue commands
	always_comb begin
		push_ok = !out_valid_q || out_ready;
		pend = (cnt_q != '0);
		last_bit = (cnt_q == hufd_pkg::CNT_W'(hufd_pkg::CODE_W));
		leaf_e = (state_q == ST_WALK) && pend && sts.leaf;
		step = (state_q == ST_WALK) && !(leaf_e && hold_v_q && !push_ok);
		flush_ok = !hold_v_q || push_ok;
		in_ready = (state_q == ST_IDLE) || ((state_q == ST_FLUSH) && flush_ok);
		accept = in_valid && in_ready;
		acc_decode = accept && (in_action == hufd_pkg::ACT_DECODE);

		cmd.write_node = accept && (in_action == hufd_pkg::ACT_WRITE);
		cmd.load = acc_decode;
		cmd.go_root = cmd.write_node || cfg_wr;
		cmd.step = step;
		cmd.eval = (state_q == ST_WALK) && pend;
		cmd.issue = step && !last_bit;
		cmd.hold_load = step && leaf_e;
		cmd.push = (step && leaf_e && hold_v_q)
			|| ((state_q == ST_FLUSH) && hold_v_q && push_ok);
		cmd.push_last = (state_q == ST_FLUSH);
	end

	assign out_valid = out_valid_q;

	// Hold state, bit count, held-symbol flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			hold_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_decode) begin
						state_q <= ST_WALK;
						cnt_q <= '0;
					end
				end
				ST_WALK: begin
					if (step) begin
						if (leaf_e) begin
							hold_v_q <= 1'b1;
						end
						if (last_bit) begin
							state_q <= ST_FLUSH;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (flush_ok) begin
						hold_v_q <= 1'b0;
						cnt_q <= '0;
						state_q <= acc_decode ? ST_WALK : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/huffman_tree_bit_decoder.sv @@
// Huffman decoder walking a code tree held in a 512-entry node table.
// Input channel (in_valid/in_ready/in_data): an item either writes one node
// (left child, right child, symbol) or carries one code byte to decode,
// most significant bit first; a one bit steps left, a zero bit right.
// Output channel (out_valid/out_ready/out_data): one item per decoded
// symbol, with last set on the final symbol of its code byte.
// APB port: register root_index at byte address 0; writing it, or any node
// write, returns the walk to the root.
// A code byte is walked as eight dependent node table reads, one per bit,
// then the last read is evaluated, then the held final symbol is released
// while the next item can be taken. Each symbol is held back so that last
// can be set. A symbol leaves when the next symbol of its byte is found;
// the final symbol leaves with last set once its code byte is walked.
// Reset clears the walk to node 0 and root_index to 0; the node table is
// not cleared and must be written before it is used.
// When the receiver stalls, the walk holds on a second pending symbol and
// input ready stays low until the output register drains.
module huffman_tree_bit_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hufd_pkg::in_t       in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hufd_pkg::out_t      out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [hufd_pkg::ROOT_W-1:0] root_q;
	logic cfg_wr;
	logic reg_sel;
	hufd_pkg::cmd_t cmd;
	hufd_pkg::sts_t sts;

	// Decode register writes and reads
	assign pready = 1'b1;
	assign reg_sel = (paddr[2] == hufd_pkg::REG_ROOT);
	assign cfg_wr = psel && penable && pwrite && reg_sel;
	assign prdata = reg_sel ? {{(32 - hufd_pkg::ROOT_W){1'b0}}, root_q} : '0;

	// Hold the root index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (cfg_wr) begin
			root_q <= pwdata[hufd_pkg::ROOT_W-1:0];
		end
	end

	hufd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (in_data.action),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_wr    (cfg_wr),
		.sts       (sts),
		.cmd       (cmd)
	);

	hufd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_data    (in_data),
		.root_index (root_q),
		.sts        (sts),
		.out_data   (out_data)
	);

endmodule

@@ test/huffman_tree_bit_decoder_test.sv @@
module huffman_tree_bit_decoder_test;

	localparam int REG_SPARE = 1;
	localparam int RANDOM_ITEMS = 330;
	localparam int STALL_LIMIT = 4000;
	localparam int END_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 16;

	// Tree walk predictor: node table copy, walk position and symbols owed
	class decode_tracker;
		hufd_pkg::node_t node_table [hufd_pkg::NODE_COUNT];
		bit written [hufd_pkg::NODE_COUNT];
		logic [hufd_pkg::IDX_W-1:0] known_nodes [$];
		logic [hufd_pkg::IDX_W-1:0] walk_pos;
		logic [hufd_pkg::ROOT_W-1:0] root;
		hufd_pkg::out_t pending_symbols [$];
		int symbols_seen;
		int decode_bytes;

		function new();
			walk_pos = '0;
			root = '0;
			symbols_seen = 0;
			decode_bytes = 0;
		endfunction

		function void set_register(input int index, input logic [31:0] value);
			if (index == hufd_pkg::REG_ROOT) begin
				root = value[hufd_pkg::ROOT_W-1:0];
				walk_pos = root;
			end
		endfunction

		function logic [hufd_pkg::IDX_W-1:0] pick_known();
			return known_nodes[$urandom_range(0, known_nodes.size() - 1)];
		endfunction

		// True when every table read for this byte hits a written entry
		function bit walk_is_defined(input logic [hufd_pkg::CODE_W-1:0] code);
			logic [hufd_pkg::IDX_W-1:0] pos;
			pos = walk_pos;
			for (int b = hufd_pkg::CODE_W - 1; b >= 0; b--) begin
				if (!written[pos])
					return 1'b0;
				pos = code[b] ? node_table[pos].left : node_table[pos].right;
				if (!written[pos])
					return 1'b0;
				if (node_table[pos].sym != '0)
					pos = root;
			end
			return 1'b1;
		endfunction

		// Store a node, or walk one code byte and queue its symbols
		function void note_item(input hufd_pkg::in_t item);
			hufd_pkg::node_t entry;
			logic [hufd_pkg::IDX_W-1:0] step_to;
			hufd_pkg::out_t res;
			int count;
			count = 0;
			if (item.action == hufd_pkg::ACT_WRITE) begin
				node_table[item.node_index] = {item.left_child, item.right_child,
					item.node_symbol};
				if (!written[item.node_index])
					known_nodes.push_back(item.node_index);
				written[item.node_index] = 1'b1;
				walk_pos = root;
			end else begin
				decode_bytes++;
				for (int b = hufd_pkg::CODE_W - 1; b >= 0; b--) begin
					entry = node_table[walk_pos];
					step_to = item.code_byte[b] ? entry.left : entry.right;
					walk_pos = step_to;
					if (node_table[step_to].sym != '0) begin
						res.symbol = node_table[step_to].sym;
						res.last = 1'b0;
						pending_symbols.push_back(res);
						count++;
						walk_pos = root;
					end
				end
				// Flag the final symbol of this byte
				if (count > 0) begin
					res = pending_symbols[pending_symbols.size() - 1];
					res.last = 1'b1;
					pending_symbols[pending_symbols.size() - 1] = res;
				end
			end
		endfunction

		function bit check_symbol(input hufd_pkg::out_t got, output string why);
			hufd_pkg::out_t want;
			why = "";
			if (pending_symbols.size() == 0) begin
				why = $sformatf("symbol %02h last %0b with nothing outstanding",
					got.symbol, got.last);
				return 1'b0;
			end
			want = pending_symbols.pop_front();
			symbols_seen++;
			if (got.symbol !== want.symbol || got.last !== want.last) begin
				why = $sformatf("symbol %02h/%02h last %0b/%0b (got/expected)",
					got.symbol, want.symbol, got.last, want.last);
				return 1'b0;
			end
			return 1'b1;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	hufd_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	hufd_pkg::out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	decode_tracker tracker;
	int error_count = 0;
	int items_sent = 0;
	int root_settings = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit gaps_on = 1'b1;
	string mismatch_note;

	huffman_tree_bit_decoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string why);
		$display("MISMATCH at %0t: %s", $time, why);
		error_count++;
	endtask

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40)
			: $urandom_range(0, 2);
	endfunction

	// Check each symbol item and stall the output at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (!tracker.check_symbol(out_data, mismatch_note))
					report_mismatch(mismatch_note);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!gaps_on || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall_left = pick_gap();
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("huffman_tree_bit_decoder_test: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic hufd_pkg::in_t random_item(input logic act);
		hufd_pkg::in_t item;
		item.action = act;
		item.node_index = hufd_pkg::IDX_W'($urandom_range(0, hufd_pkg::NODE_COUNT - 1));
		item.left_child = hufd_pkg::IDX_W'($urandom_range(0, hufd_pkg::NODE_COUNT - 1));
		item.right_child = hufd_pkg::IDX_W'($urandom_range(0, hufd_pkg::NODE_COUNT - 1));
		item.node_symbol = hufd_pkg::SYM_W'($urandom_range(0, 255));
		item.code_byte = hufd_pkg::CODE_W'($urandom_range(0, 255));
		return item;
	endfunction

	function automatic hufd_pkg::in_t node_item(input logic [hufd_pkg::IDX_W-1:0] idx,
		input logic [hufd_pkg::IDX_W-1:0] l, input logic [hufd_pkg::IDX_W-1:0] r,
		input logic [hufd_pkg::SYM_W-1:0] sym);
		hufd_pkg::in_t item;
		item = random_item(hufd_pkg::ACT_WRITE);
		item.node_index = idx;
		item.left_child = l;
		item.right_child = r;
		item.node_symbol = sym;
		return item;
	endfunction

	function automatic hufd_pkg::in_t code_item(input logic [hufd_pkg::CODE_W-1:0] code);
		hufd_pkg::in_t item;
		item = random_item(hufd_pkg::ACT_DECODE);
		item.code_byte = code;
		return item;
	endfunction

	// Overwrite any entry, pointing only at written nodes
	function automatic hufd_pkg::in_t noise_write();
		hufd_pkg::in_t item;
		item = random_item(hufd_pkg::ACT_WRITE);
		item.left_child = tracker.pick_known();
		item.right_child = tracker.pick_known();
		if ($urandom_range(0, 1))
			item.node_symbol = '0;
		return item;
	endfunction

	// Present one item, hold it until accepted, then predict
	task automatic send_item(input hufd_pkg::in_t item);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		tracker.note_item(item);
		items_sent++;
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (tracker.pending_symbols.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input int index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(index << 2);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_register(index, value);
		if (index == hufd_pkg::REG_ROOT)
			root_settings++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Grow a random full tree from the root, biased towards deep chains
	task automatic build_tree(input logic [hufd_pkg::IDX_W-1:0] top, input int leaves);
		bit taken [hufd_pkg::NODE_COUNT];
		logic [hufd_pkg::IDX_W-1:0] open_nodes [$];
		logic [hufd_pkg::IDX_W-1:0] kids [2];
		logic [hufd_pkg::IDX_W-1:0] node;
		int pick;
		taken[top] = 1'b1;
		open_nodes.push_back(top);
		while (open_nodes.size() < leaves) begin
			pick = $urandom_range(0, 1) ? open_nodes.size() - 1
				: $urandom_range(0, open_nodes.size() - 1);
			node = open_nodes[pick];
			open_nodes.delete(pick);
			foreach (kids[k]) begin
				do kids[k] = hufd_pkg::IDX_W'($urandom_range(0, hufd_pkg::NODE_COUNT - 1));
				while (taken[kids[k]]);
				taken[kids[k]] = 1'b1;
			end
			send_item(node_item(node, kids[0], kids[1], '0));
			if ($urandom_range(0, 1)) begin
				open_nodes.push_back(kids[0]);
				open_nodes.push_back(kids[1]);
			end else begin
				open_nodes.push_back(kids[1]);
				open_nodes.push_back(kids[0]);
			end
		end
		// Leaves keep random children, which are never followed
		foreach (open_nodes[i])
			send_item(node_item(open_nodes[i], hufd_pkg::IDX_W'($urandom),
				hufd_pkg::IDX_W'($urandom), hufd_pkg::SYM_W'($urandom_range(1, 255))));
	endtask

	// Pick a byte whose walk stays on written entries
	task automatic send_decode();
		hufd_pkg::in_t item;
		int tries;
		item = random_item(hufd_pkg::ACT_DECODE);
		tries = 0;
		do begin
			case ($urandom_range(0, 9))
				0: item.code_byte = '0;
				1: item.code_byte = '1;
				default: item.code_byte = hufd_pkg::CODE_W'($urandom_range(0, 255));
			endcase
			tries++;
		end while (!tracker.walk_is_defined(item.code_byte) && tries < 16);
		if (!tracker.walk_is_defined(item.code_byte))
			item = noise_write();
		send_item(item);
	endtask

	initial begin
		logic [hufd_pkg::IDX_W-1:0] top;
		logic [31:0] value;
		int phase;
		int directed_items;
		int n;
		tracker = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Small tree at root 0 with a loop back to the root through node 511
		cfg_write(hufd_pkg::REG_ROOT, 32'd0);
		send_item(node_item(9'd0, 9'd1, 9'd511, 8'h00));
		send_item(node_item(9'd1, 9'd0, 9'd511, 8'hFF));
		send_item(node_item(9'd511, 9'd2, 9'd0, 8'h00));
		send_item(node_item(9'd2, 9'd511, 9'd0, 8'h01));
		// Eight symbols, none, a walk carried into the next byte, alternating bits
		send_item(code_item(8'hFF));
		send_item(code_item(8'h00));
		send_item(code_item(8'h80));
		send_item(code_item(8'hC0));
		send_item(code_item(8'h55));
		send_item(code_item(8'hAA));
		// A write mid-walk returns to the root
		send_item(node_item(9'd2, 9'd511, 9'd0, 8'h80));
		send_item(code_item(8'h40));
		send_item(code_item(8'h01));
		send_item(code_item(8'hAA));
		// Unmapped register must leave the walk where it is
		release_input();
		wait_drain();
		cfg_write(REG_SPARE, 32'hFFFF_FFFF);
		send_item(code_item(8'h80));
		// Highest root, with junk above the index bits
		release_input();
		wait_drain();
		cfg_write(hufd_pkg::REG_ROOT, 32'hABCD_E000 | 32'(hufd_pkg::NODE_COUNT - 1));
		send_item(code_item(8'h5A));
		send_item(code_item(8'hFF));
		send_item(node_item(9'd511, 9'd2, 9'd0, 8'h00));
		send_item(code_item(8'h3C));
		directed_items = items_sent;

		// Random phases: new root, fresh tree, then mostly decodes
		phase = 0;
		while (items_sent < directed_items + RANDOM_ITEMS) begin
			release_input();
			wait_drain();
			if (phase == 0)
				top = '1;
			else if (phase == 1)
				top = '0;
			else
				top = hufd_pkg::IDX_W'($urandom_range(0, hufd_pkg::NODE_COUNT - 1));
			value = $urandom;
			value[hufd_pkg::ROOT_W-1:0] = top;
			cfg_write(hufd_pkg::REG_ROOT, value);
			gaps_on = (phase % 4 != 3);
			build_tree(top, $urandom_range(2, 14));
			for (n = 0; n < 30; n++) begin
				if (n == 15 && (phase == 0 || $urandom_range(0, 1))) begin
					release_input();
					wait_drain();
				end
				if ($urandom_range(0, 9) == 0)
					send_item(noise_write());
				else
					send_decode();
			end
			phase++;
		end

		// Let the last symbols drain, then look for strays
		release_input();
		gaps_on = 1'b1;
		for (n = 0; n < END_LIMIT && tracker.pending_symbols.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.pending_symbols.size() != 0)
			report_mismatch($sformatf("%0d symbols never arrived",
				tracker.pending_symbols.size()));

		$display("Sent %0d items (%0d code bytes) over %0d root settings;",
			items_sent, tracker.decode_bytes, root_settings);
		$display("checked %0d decoded symbols, %0d mismatches.",
			tracker.symbols_seen, error_count);
		if (error_count == 0) begin
			$display("huffman_tree_bit_decoder_test: clean");
		end else begin
			$display("huffman_tree_bit_decoder_test: errors");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/hufd_pkg.sv
rtl/hufd_dp.sv
rtl/hufd_ctrl.sv
rtl/huffman_tree_bit_decoder.sv
test/huffman_tree_bit_decoder_test.sv
